// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: expr");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

// File: hw/rtl/csbr_pkg.sv
package csbr_pkg;

   localparam int FRAMES_DEFAULT = 64;
   localparam int KEY_BITS       = 32;
   localparam int CAP_W          = 3;
   localparam int ROUND_W        = CAP_W + 1;
   localparam int FRAME_PORT_W   = 6;
   localparam int STATUS_W       = 2;
   localparam int FUNC_W         = 2;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 3'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FETCH  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_UNLOCK = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT       = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INSERTED  = 2'd2,
      ST_NO_FRAME  = 2'd3
   } status_type;

   typedef struct packed {
      logic             pinned;
      logic [CAP_W-1:0] count;
   } meta_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_MISS  = 5'b00100,
      S_SW_RD = 5'b01000,
      S_SW_EV = 5'b10000
   } state_type;

endpackage

// File: hw/rtl/clock_sweep_buffer_replacer_top.sv
// func 3 answers straight from idle without a lookup; a lookup reads one key per cycle
//   from frame 0 upward and stops at the first hit or after the last filled frame
// throughput: one item at a time, busy stays high until the result strobe; func 3 never raises busy
// an insert into a full table sweeps frames from the hand, each a meta read then a write back,
//   for at most usage_cap+1 rounds after the lookup before it gives up
// reset: synchronous, clears fill count, hand, state and result strobe, usage_cap to 5; no receiver stall
module clock_sweep_buffer_replacer_top #(
   parameter int FRAMES = csbr_pkg::FRAMES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                start,
   output logic                                busy,
   input  logic [csbr_pkg::FUNC_W-1:0]         req_func,
   input  logic [csbr_pkg::KEY_BITS-1:0]       req_key,
   // result side
   output logic                                rsp_strobe,
   output logic [csbr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [csbr_pkg::FRAME_PORT_W-1:0]   rsp_frame,
   output logic                                rsp_evicted,
   output logic [csbr_pkg::KEY_BITS-1:0]       rsp_evicted_key,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [csbr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [csbr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [csbr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import csbr_pkg::*;

`include "assert_macros.svh"

   localparam int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FILL_W = IW + 1;
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FRAMES);
   localparam logic [IW-1:0]     LAST_FRAME = IW'(FRAMES - 1);

   // frame store: key memory plus pinned/count memory, one synchronous read port and one write port each
   // frames fill from index 0 upward and never empty again, so frames below
   // fill_ff are exactly the valid ones and the memories need no clearing
   logic [KEY_BITS-1:0] key_mem [FRAMES];
   meta_type            meta_mem [FRAMES];
   logic [KEY_BITS-1:0] key_rdata_ff;
   meta_type            meta_rdata_ff;

   logic [IW-1:0]       rd_addr;
   logic [IW-1:0]       wr_addr;
   logic                key_we;
   logic                meta_we;
   meta_type            meta_wdata;

   // control state
   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [IW-1:0]       hand_ff, hand_in;
   logic [IW-1:0]       origin_ff, origin_in;
   logic [ROUND_W-1:0]  rounds_ff, rounds_in;
   logic [IW-1:0]       scan_idx_ff, scan_idx_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;

   // latched item
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   // result register
   logic                rsp_strobe_ff, rsp_strobe_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [IW-1:0]       rsp_idx_ff, rsp_idx_in;
   logic                rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0] rsp_evkey_ff, rsp_evkey_in;

   logic [IW+FRAME_PORT_W-1:0] rsp_idx_ext;
   logic [FILL_W-1:0]          rsp_idx_wide;
   logic                       rsp_inserted;
   logic [FILL_W-1:0]          scan_next_cnt;
   logic [IW-1:0]              hand_nx;
   logic [ROUND_W-1:0]         rounds_nx;
   logic                       scan_hit;
   logic                       scan_last;
   logic                       csr_write;

   assign busy    = (state_ff != S_IDLE);
   assign pready  = 1'b1;
   assign prdata  = {{(CSR_DATA_W-CAP_W){1'b0}}, cap_ff};
   // only one register: every address lands on usage_cap
   assign csr_write = psel && penable && pwrite && pready;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_idx_ext     = {{FRAME_PORT_W{1'b0}}, rsp_idx_ff};
   assign rsp_frame       = rsp_idx_ext[FRAME_PORT_W-1:0];
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;
   assign rsp_idx_wide    = {1'b0, rsp_idx_ff};
   assign rsp_inserted    = rsp_strobe_ff && (rsp_status_ff == ST_INSERTED);

   // lookup compare against the entry read in the previous cycle
   assign scan_hit      = (key_rdata_ff == key_ff);
   assign scan_next_cnt = {1'b0, scan_idx_ff} + FILL_W'(1);
   assign scan_last     = (scan_next_cnt == fill_ff);

   // hand wraps at the table end; a round ends when it is back at the origin
   assign hand_nx   = (hand_ff == LAST_FRAME) ? '0 : hand_ff + IW'(1);
   assign rounds_nx = rounds_ff + ROUND_W'(hand_nx == origin_ff);

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (meta_we) begin
         meta_mem[wr_addr] <= meta_wdata;
      end
      key_rdata_ff  <= key_mem[rd_addr];
      meta_rdata_ff <= meta_mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      hand_in        = hand_ff;
      origin_in      = origin_ff;
      rounds_in      = rounds_ff;
      scan_idx_in    = scan_idx_ff;
      cap_in         = csr_write ? pwdata[CAP_W-1:0] : cap_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      rd_addr        = scan_idx_ff + IW'(1);
      wr_addr        = scan_idx_ff;
      key_we         = 1'b0;
      meta_we        = 1'b0;
      meta_wdata     = '0;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = ST_NOT_FOUND;
      rsp_idx_in     = '0;
      rsp_evicted_in = 1'b0;
      rsp_evkey_in   = '0;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (start) begin
               func_in     = req_func;
               key_in      = req_key;
               scan_idx_in = '0;
               if (req_func == FUNC_UNUSED) begin
                  // unused code: answer not found, touch nothing
                  rsp_strobe_in = 1'b1;
               end else if (fill_ff == '0) begin
                  state_in = S_MISS;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (scan_hit) begin
               // read-modify-write of the hit frame's meta
               meta_we = 1'b1;
               if (func_ff == FUNC_UNLOCK) begin
                  meta_wdata.pinned = 1'b0;
                  meta_wdata.count  = meta_rdata_ff.count;
               end else begin
                  meta_wdata.pinned = 1'b1;
                  meta_wdata.count  = (meta_rdata_ff.count < cap_ff) ?
                                      meta_rdata_ff.count + CAP_W'(1) :
                                      meta_rdata_ff.count;
               end
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_HIT;
               rsp_idx_in    = scan_idx_ff;
               state_in      = S_IDLE;
            end else if (scan_last) begin
               state_in = S_MISS;
            end else begin
               scan_idx_in = scan_idx_ff + IW'(1);
            end
         end

         S_MISS: begin
            if (func_ff != FUNC_INSERT) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (fill_ff != FILL_FULL) begin
               // lowest empty frame is the fill point
               wr_addr           = fill_ff[IW-1:0];
               key_we            = 1'b1;
               meta_we           = 1'b1;
               meta_wdata.pinned = 1'b1;
               meta_wdata.count  = CAP_W'(1);
               fill_in           = fill_ff + FILL_W'(1);
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_INSERTED;
               rsp_idx_in        = fill_ff[IW-1:0];
               state_in          = S_IDLE;
            end else begin
               origin_in = hand_ff;
               rounds_in = '0;
               state_in  = S_SW_RD;
            end
         end

         S_SW_RD: begin
            rd_addr  = hand_ff;
            state_in = S_SW_EV;
         end

         S_SW_EV: begin
            // write back lands before the next read, so no forwarding is needed
            wr_addr = hand_ff;
            hand_in = hand_nx;
            if (!meta_rdata_ff.pinned && (meta_rdata_ff.count == '0)) begin
               key_we            = 1'b1;
               meta_we           = 1'b1;
               meta_wdata.pinned = 1'b1;
               meta_wdata.count  = CAP_W'(1);
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = ST_INSERTED;
               rsp_idx_in        = hand_ff;
               rsp_evicted_in    = 1'b1;
               rsp_evkey_in      = key_rdata_ff;
               state_in          = S_IDLE;
            end else begin
               if (!meta_rdata_ff.pinned) begin
                  meta_we           = 1'b1;
                  meta_wdata.pinned = 1'b0;
                  meta_wdata.count  = meta_rdata_ff.count - CAP_W'(1);
               end
               if (rounds_nx > {1'b0, cap_ff}) begin
                  // every candidate stayed pinned or hot: give up
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_NO_FRAME;
                  state_in      = S_IDLE;
               end else begin
                  rounds_in = rounds_nx;
                  state_in  = S_SW_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         hand_ff       <= '0;
         cap_ff        <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         hand_ff       <= hand_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      origin_ff      <= origin_in;
      rounds_ff      <= rounds_in;
      scan_idx_ff    <= scan_idx_in;
      func_ff        <= func_in;
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   // checks
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_FULL)
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe_ff)
   `ASSERT_IMPLIES(a_insert_in_fill, clock, reset, rsp_inserted, rsp_idx_wide < fill_ff)
   `ASSERT_IMPLIES(a_evict_when_full, clock, reset, rsp_strobe_ff && rsp_evicted_ff, fill_ff == FILL_FULL)

endmodule
